/* rtl/tcce_pkg.sv */
// Package for the text console character engine.
// Holds word and command types, character codes and the controller states.
// No dependencies.
package tcce_pkg;

    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;

    localparam logic [7:0] CH_NEWLINE   = 8'd10;
    localparam logic [7:0] CH_RETURN    = 8'd13;
    localparam logic [7:0] CH_TAB       = 8'd9;
    localparam logic [7:0] CH_BACKSPACE = 8'd8;
    localparam logic [7:0] CH_BLANK     = 8'd32;
    localparam logic [7:0] TAB_STEP     = 8'd4;
    localparam logic [7:0] RESET_COLOR  = 8'h0F;

    localparam logic [1:0] KIND_PUT   = 2'd0;
    localparam logic [1:0] KIND_CLEAR = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] char_code;
        logic [6:0] read_col;
        logic [4:0] read_row;
    } cmd_word_t;

    typedef struct packed {
        logic [6:0] cursor_col;
        logic [4:0] cursor_row;
        logic [7:0] cell_char;
        logic [7:0] cell_color;
        logic       scrolled;
    } rsp_word_t;

    typedef enum logic [1:0] {
        SWEEP_ZERO,
        SWEEP_SECOND_ROW,
        SWEEP_BOTTOM_ROW
    } sweep_start_t;

    typedef struct packed {
        logic         capture;
        logic         put_step;
        logic         home;
        logic         sweep_load;
        sweep_start_t sweep_start;
        logic         sweep_inc;
        logic         fill_we;
        logic         fill_init;
        logic         copy_rd;
        logic         cell_rd;
        logic         res_load;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] kind;
        logic       scroll_need;
        logic       sweep_last;
        logic       rsp_free;
    } dp_status_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_CLEAR,
        ST_COPY,
        ST_DRAIN,
        ST_BLANK,
        ST_DONE
    } ctrl_state_t;

endpackage

/* rtl/tcce_ctrl.sv */
// Controller state machine of the text console character engine.
// Sequences the reset fill, clear, scroll and result hand-off; uses tcce_pkg.
module tcce_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    output logic                 cmd_stall,
    input  tcce_pkg::dp_status_t status,
    output tcce_pkg::dp_cmd_t    cmd
);
    import tcce_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_INIT:
            begin
                if (status.sweep_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                unique case (status.kind)
                    KIND_PUT:   state_next = status.scroll_need ? ST_COPY : ST_DONE;
                    KIND_CLEAR: state_next = ST_CLEAR;
                    default:    state_next = ST_DONE;
                endcase
            end
            ST_CLEAR, ST_BLANK:
            begin
                if (status.sweep_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_COPY:
            begin
                if (status.sweep_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_BLANK;
            end
            ST_DONE:
            begin
                if (status.rsp_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        cmd_stall = 1'b1;
        unique case (state_reg)
            ST_INIT:
            begin
                cmd.fill_we   = 1'b1;
                cmd.fill_init = 1'b1;
                cmd.sweep_inc = 1'b1;
            end
            ST_IDLE:
            begin
                cmd_stall   = 1'b0;
                cmd.capture = cmd_valid;
            end
            ST_EXEC:
            begin
                unique case (status.kind)
                    KIND_PUT:
                    begin
                        cmd.put_step    = 1'b1;
                        cmd.sweep_load  = status.scroll_need;
                        cmd.sweep_start = SWEEP_SECOND_ROW;
                    end
                    KIND_CLEAR:
                    begin
                        cmd.home        = 1'b1;
                        cmd.sweep_load  = 1'b1;
                        cmd.sweep_start = SWEEP_ZERO;
                    end
                    KIND_READ:
                    begin
                        cmd.cell_rd = 1'b1;
                    end
                    default:
                    begin
                        cmd.cell_rd = 1'b0;
                    end
                endcase
            end
            ST_CLEAR, ST_BLANK:
            begin
                cmd.fill_we   = 1'b1;
                cmd.sweep_inc = 1'b1;
            end
            ST_COPY:
            begin
                cmd.copy_rd   = 1'b1;
                cmd.sweep_inc = 1'b1;
            end
            ST_DRAIN:
            begin
                cmd.sweep_load  = 1'b1;
                cmd.sweep_start = SWEEP_BOTTOM_ROW;
            end
            ST_DONE:
            begin
                cmd.res_load = status.rsp_free;
            end
            default:
            begin
                cmd_stall = 1'b1;
            end
        endcase
    end

endmodule

/* rtl/tcce_dp.sv */
// Datapath of the text console character engine.
// Holds the cell store, cursor, color register, sweep counter and result register;
// driven by tcce_ctrl commands and uses tcce_pkg.
module tcce_dp #(
    parameter int COLUMNS = tcce_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcce_pkg::ROWS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tcce_pkg::cmd_word_t  cmd_word,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [7:0]           cfg_data,
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output tcce_pkg::rsp_word_t  rsp_word,
    input  tcce_pkg::dp_cmd_t    cmd,
    output tcce_pkg::dp_status_t status
);
    import tcce_pkg::*;

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);

    logic [15:0]   mem [CELLS];
    logic [15:0]   rdata_reg;

    cmd_word_t     item_reg;
    logic [6:0]    col_reg;
    logic [4:0]    row_reg;
    logic [7:0]    color_reg;
    logic [AW-1:0] sweep_reg;
    logic [AW-1:0] sweep_next;
    logic          copy_pend_reg;
    logic [AW-1:0] copy_addr_reg;
    logic          scrolled_reg;
    logic          hit_reg;
    logic          rsp_valid_reg;
    logic          rsp_valid_next;
    rsp_word_t     rsp_word_reg;
    rsp_word_t     rsp_word_next;

    logic [6:0]    put_col;
    logic [4:0]    put_row;
    logic          put_we;
    logic [7:0]    put_char;
    logic [6:0]    put_wcol;
    logic          advance;
    logic          scroll_need;
    logic [7:0]    col_ext;
    logic [7:0]    col_step;
    logic [5:0]    row_step;
    logic [AW:0]   put_addr_full;
    logic [AW:0]   cell_addr_full;
    logic          in_range;

    logic          we;
    logic [AW-1:0] waddr;
    logic [15:0]   wdata;
    logic          re;
    logic [AW-1:0] raddr;
    logic [7:0]    fill_color;

    always_comb
    begin
        col_ext  = {1'b0, col_reg};
        col_step = col_ext + 8'd1;
        put_col  = col_reg;
        put_we   = 1'b0;
        put_char = item_reg.char_code;
        put_wcol = col_reg;
        advance  = 1'b0;
        unique case (item_reg.char_code)
            CH_NEWLINE:
            begin
                advance = 1'b1;
            end
            CH_RETURN:
            begin
                put_col = '0;
            end
            CH_TAB:
            begin
                col_step = (col_ext + TAB_STEP) & ~(TAB_STEP - 8'd1);
                if (col_step >= 8'(COLUMNS))
                begin
                    advance = 1'b1;
                end
                else
                begin
                    put_col = col_step[6:0];
                end
            end
            CH_BACKSPACE:
            begin
                if (col_reg != '0)
                begin
                    put_col  = col_reg - 7'd1;
                    put_wcol = col_reg - 7'd1;
                    put_we   = 1'b1;
                    put_char = CH_BLANK;
                end
            end
            default:
            begin
                put_we = 1'b1;
                if (col_step >= 8'(COLUMNS))
                begin
                    advance = 1'b1;
                end
                else
                begin
                    put_col = col_step[6:0];
                end
            end
        endcase

        row_step    = {1'b0, row_reg} + 6'd1;
        put_row     = row_reg;
        scroll_need = 1'b0;
        if (advance)
        begin
            put_col = '0;
            if (row_step >= 6'(ROWS))
            begin
                scroll_need = 1'b1;
                put_row     = 5'(ROWS - 1);
            end
            else
            begin
                put_row = row_step[4:0];
            end
        end
    end

    assign put_addr_full  = (AW + 1)'(row_reg) * (AW + 1)'(COLUMNS) + (AW + 1)'(put_wcol);
    assign cell_addr_full = (AW + 1)'(item_reg.read_row) * (AW + 1)'(COLUMNS)
                          + (AW + 1)'(item_reg.read_col);
    assign in_range = ({1'b0, item_reg.read_col} < 8'(COLUMNS))
                   && ({1'b0, item_reg.read_row} < 6'(ROWS));

    assign fill_color = cmd.fill_init ? RESET_COLOR : color_reg;

    always_comb
    begin
        we    = 1'b0;
        waddr = sweep_reg;
        wdata = {fill_color, CH_BLANK};
        priority if (copy_pend_reg)
        begin
            we    = 1'b1;
            waddr = copy_addr_reg;
            wdata = rdata_reg;
        end
        else if (cmd.fill_we)
        begin
            we = 1'b1;
        end
        else if (cmd.put_step && put_we)
        begin
            we    = 1'b1;
            waddr = put_addr_full[AW-1:0];
            wdata = {color_reg, put_char};
        end
    end

    assign re    = cmd.copy_rd || (cmd.cell_rd && in_range);
    assign raddr = cmd.cell_rd ? cell_addr_full[AW-1:0] : sweep_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    always_comb
    begin
        sweep_next = sweep_reg;
        if (cmd.sweep_load)
        begin
            unique case (cmd.sweep_start)
                SWEEP_SECOND_ROW: sweep_next = AW'(COLUMNS);
                SWEEP_BOTTOM_ROW: sweep_next = AW'(CELLS - COLUMNS);
                default:          sweep_next = '0;
            endcase
        end
        else if (cmd.sweep_inc)
        begin
            sweep_next = sweep_reg + AW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            color_reg     <= RESET_COLOR;
            sweep_reg     <= '0;
            copy_pend_reg <= 1'b0;
            scrolled_reg  <= 1'b0;
            hit_reg       <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            sweep_reg     <= sweep_next;
            copy_pend_reg <= cmd.copy_rd;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                color_reg <= cfg_data;
            end
            if (cmd.capture)
            begin
                scrolled_reg <= 1'b0;
                hit_reg      <= 1'b0;
            end
            if (cmd.put_step)
            begin
                col_reg      <= put_col;
                row_reg      <= put_row;
                scrolled_reg <= scroll_need;
            end
            if (cmd.home)
            begin
                col_reg <= '0;
                row_reg <= '0;
            end
            if (cmd.cell_rd)
            begin
                hit_reg <= in_range;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        copy_addr_reg <= sweep_reg - AW'(COLUMNS);
        if (cmd.capture)
        begin
            item_reg <= cmd_word;
        end
        if (cmd.res_load)
        begin
            rsp_word_reg <= rsp_word_next;
        end
    end

    always_comb
    begin
        rsp_word_next.cursor_col = col_reg;
        rsp_word_next.cursor_row = row_reg;
        rsp_word_next.cell_char  = hit_reg ? rdata_reg[7:0] : 8'd0;
        rsp_word_next.cell_color = hit_reg ? rdata_reg[15:8] : 8'd0;
        rsp_word_next.scrolled   = scrolled_reg;
        if (cmd.res_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    assign rsp_valid          = rsp_valid_reg;
    assign rsp_word           = rsp_word_reg;
    assign status.kind        = item_reg.kind;
    assign status.scroll_need = scroll_need;
    assign status.sweep_last  = (sweep_reg == AW'(CELLS - 1));
    assign status.rsp_free    = !rsp_valid_reg || !rsp_stall;

endmodule

/* rtl/text_console_char_engine.sv */
// Top level of the text console character engine.
// Joins the controller tcce_ctrl and the datapath tcce_dp; uses tcce_pkg.
//
// Usage:
// The command channel (cmd_valid, cmd_stall, cmd_word) takes one word per
// operation: put a character, clear the screen, or read one cell. The
// response channel (rsp_valid, rsp_stall, rsp_word) returns exactly one word
// per command with the cursor position after it. The configuration channel
// (cfg_valid, cfg_ready, cfg_data) writes the text color at any time; it is
// meant to be written only while no command is in flight.
// A put without scrolling and a read pass through the execute and done
// states before the response word is registered; a clear and a put that
// scrolls also sweep the cell store, which, with one read and one write port,
// is rewritten one cell per cycle. Commands are handled one at a time; the
// next command is accepted in the cycle after a result has moved into the
// output register.
// After reset the store is filled with blanks in color 0x0F, one cell per
// cycle, and cmd_stall stays high until the fill is done.
// While rsp_stall is high the response word holds; work on the next command
// finishes and then waits for the output register to drain.
module text_console_char_engine #(
    parameter int COLUMNS = tcce_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcce_pkg::ROWS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_stall,
    input  tcce_pkg::cmd_word_t cmd_word,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output tcce_pkg::rsp_word_t rsp_word,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [7:0]          cfg_data
);
    import tcce_pkg::*;

    dp_cmd_t    dp_cmd;
    dp_status_t dp_status;

    assign cfg_ready = 1'b1;

    tcce_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .status    (dp_status),
        .cmd       (dp_cmd)
    );

    tcce_dp #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_word  (cmd_word),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_word  (rsp_word),
        .cmd       (dp_cmd),
        .status    (dp_status)
    );

endmodule

/* rtl/tcce_checker.sv */
// Port-level checker for the text console character engine.
// Watches the top level ports only and is attached by the bind below; uses tcce_pkg.
module tcce_checker #(
    parameter int COLUMNS = tcce_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcce_pkg::ROWS_DEF
) (
    input logic                clk,
    input logic                rst_n,
    input logic                cmd_valid,
    input logic                cmd_stall,
    input logic                rsp_valid,
    input logic                rsp_stall,
    input tcce_pkg::rsp_word_t rsp_word
);
    import tcce_pkg::*;

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
        else $error("Stalled response word changed or was dropped.");

    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> ({1'b0, rsp_word.cursor_col} < 8'(COLUMNS))
                   && ({1'b0, rsp_word.cursor_row} < 6'(ROWS)))
        else $error("Reported cursor lies outside the screen.");

    a_scroll_pos: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_word.scrolled |->
            rsp_word.cursor_col == 7'd0 && rsp_word.cursor_row == 5'(ROWS - 1))
        else $error("Scroll reported without cursor at start of bottom row.");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_stall |=> cmd_stall)
        else $error("A second command was taken while one was in progress.");

endmodule

bind text_console_char_engine tcce_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_tcce_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_word  (rsp_word)
);

/* sim/text_console_char_engine_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for text_console_char_engine: puts, clears and cell reads
// are checked word by word against a behavioral screen model kept in the bench.
// Depends on tcce_pkg and the engine RTL only.
module text_console_char_engine_tb;
    import tcce_pkg::*;

    localparam int COLUMNS = COLUMNS_DEF;
    localparam int ROWS = ROWS_DEF;
    localparam int CELLS = COLUMNS * ROWS;
    localparam logic [1:0] KIND_NONE = 2'd3;
    localparam int HOLD_CYCLES = 400;
    localparam int CYCLE_LIMIT = 5_000_000;

    logic clk;
    logic rst_n = 1'b0;
    logic cmd_valid = 1'b0;
    logic cmd_stall;
    cmd_word_t cmd_word = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_word_t rsp_word;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [7:0] cfg_data = '0;

    logic [15:0] screen [CELLS];
    int unsigned pen_col;
    int unsigned pen_row;
    logic [7:0] ink;

    rsp_word_t expected_rsp [$];
    rsp_word_t want;
    int unsigned mismatch_count = 0;
    int unsigned rsp_seen = 0;
    int unsigned cmd_count = 0;
    int unsigned read_count = 0;
    int unsigned clear_count = 0;
    int unsigned scroll_count = 0;
    int unsigned cycle_count = 0;

    bit steady = 1'b0;
    int unsigned hold_ticket = 0;
    int unsigned hold_seen = 0;
    int unsigned hold_left = 0;

    text_console_char_engine #(
        .COLUMNS(COLUMNS),
        .ROWS(ROWS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cmd_valid(cmd_valid),
        .cmd_stall(cmd_stall),
        .cmd_word(cmd_word),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp_word(rsp_word),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("simulation failed");
        $finish;
    end

    // Moving past the bottom row shifts every line up and blanks the last one.
    function automatic bit line_feed();
        pen_col = 0;
        pen_row++;
        if (pen_row < ROWS)
        begin
            return 1'b0;
        end
        for (int i = 0; i < CELLS - COLUMNS; i++)
        begin
            screen[i] = screen[i + COLUMNS];
        end
        for (int i = CELLS - COLUMNS; i < CELLS; i++)
        begin
            screen[i] = {ink, CH_BLANK};
        end
        pen_row = ROWS - 1;
        return 1'b1;
    endfunction

    function automatic bit put_char(input logic [7:0] ch);
        if (ch == CH_NEWLINE)
        begin
            return line_feed();
        end
        if (ch == CH_RETURN)
        begin
            pen_col = 0;
            return 1'b0;
        end
        if (ch == CH_TAB)
        begin
            pen_col = (pen_col + TAB_STEP) / TAB_STEP * TAB_STEP;
            if (pen_col >= COLUMNS)
            begin
                return line_feed();
            end
            return 1'b0;
        end
        if (ch == CH_BACKSPACE)
        begin
            if (pen_col > 0)
            begin
                pen_col--;
                screen[pen_row * COLUMNS + pen_col] = {ink, CH_BLANK};
            end
            return 1'b0;
        end
        screen[pen_row * COLUMNS + pen_col] = {ink, ch};
        pen_col++;
        if (pen_col >= COLUMNS)
        begin
            return line_feed();
        end
        return 1'b0;
    endfunction

    function automatic rsp_word_t console_step(input cmd_word_t c);
        rsp_word_t r;
        int unsigned idx;
        r = '0;
        case (c.kind)
            KIND_PUT:
            begin
                r.scrolled = put_char(c.char_code);
            end
            KIND_CLEAR:
            begin
                for (int i = 0; i < CELLS; i++)
                begin
                    screen[i] = {ink, CH_BLANK};
                end
                pen_col = 0;
                pen_row = 0;
            end
            KIND_READ:
            begin
                if (c.read_col < COLUMNS && c.read_row < ROWS)
                begin
                    idx = c.read_row * COLUMNS + c.read_col;
                    r.cell_char = screen[idx][7:0];
                    r.cell_color = screen[idx][15:8];
                end
            end
            default:
            begin
            end
        endcase
        r.cursor_col = pen_col[6:0];
        r.cursor_row = pen_row[4:0];
        return r;
    endfunction

    function automatic cmd_word_t make_word(input logic [1:0] kind, input logic [7:0] ch,
                                            input logic [6:0] col, input logic [4:0] row);
        cmd_word_t w;
        w.kind = kind;
        w.char_code = ch;
        w.read_col = col;
        w.read_row = row;
        return w;
    endfunction

    function automatic cmd_word_t put_word(input logic [7:0] ch);
        return make_word(KIND_PUT, ch, 7'($urandom_range(0, 127)), 5'($urandom_range(0, 31)));
    endfunction

    function automatic cmd_word_t read_word(input int unsigned col, input int unsigned row);
        return make_word(KIND_READ, 8'($urandom_range(0, 255)), 7'(col), 5'(row));
    endfunction

    function automatic cmd_word_t text_item();
        int unsigned pick;
        int unsigned row;
        pick = $urandom_range(0, 99);
        if (pick < 45)
        begin
            return put_word(8'($urandom_range(32, 126)));
        end
        if (pick < 55)
        begin
            return put_word(8'($urandom_range(0, 255)));
        end
        if (pick < 60)
        begin
            return put_word(CH_TAB);
        end
        if (pick < 65)
        begin
            return put_word(CH_BACKSPACE);
        end
        if (pick < 80)
        begin
            row = (pen_row > 0 && $urandom_range(0, 1) == 1) ? pen_row - 1 : pen_row;
            return read_word($urandom_range(0, 15), row);
        end
        if (pick < 95)
        begin
            return read_word($urandom_range(0, COLUMNS - 1), $urandom_range(0, ROWS - 1));
        end
        return read_word($urandom_range(0, 127), $urandom_range(0, 31));
    endfunction

    task automatic issue_word(input cmd_word_t w);
        rsp_word_t got;
        if (!steady && $urandom_range(0, 99) < 20)
        begin
            cmd_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < 20);
        end
        cmd_valid <= 1'b1;
        cmd_word <= w;
        do
            @(posedge clk);
        while (cmd_stall);
        got = console_step(w);
        expected_rsp.push_back(got);
        cmd_count++;
        if (w.kind == KIND_READ)
        begin
            read_count++;
        end
        if (w.kind == KIND_CLEAR)
        begin
            clear_count++;
        end
        if (got.scrolled)
        begin
            scroll_count++;
        end
    endtask

    task automatic drain_responses();
        cmd_valid <= 1'b0;
        while (expected_rsp.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic set_color(input logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        ink = value;
    endtask

    task automatic test_power_up_screen();
        issue_word(read_word(0, 0));
        issue_word(read_word(COLUMNS - 1, ROWS - 1));
        issue_word(read_word(COLUMNS / 2, ROWS / 2));
        issue_word(read_word(COLUMNS, 0));
        issue_word(read_word(0, ROWS));
        issue_word(read_word(127, 31));
        issue_word(make_word(KIND_NONE, 8'hFF, 7'h7F, 5'h1F));
    endtask

    task automatic test_control_codes();
        issue_word(put_word(8'h41));
        issue_word(put_word(CH_TAB));
        issue_word(put_word(8'h00));
        issue_word(put_word(CH_TAB));
        issue_word(put_word(8'hFF));
        issue_word(put_word(CH_BACKSPACE));
        issue_word(put_word(CH_RETURN));
        issue_word(put_word(CH_BACKSPACE));
        issue_word(put_word(8'h80));
        issue_word(put_word(CH_NEWLINE));
        issue_word(read_word(0, 0));
        issue_word(read_word(4, 0));
        issue_word(read_word(8, 0));
        issue_word(read_word(1, 0));
        issue_word(make_word(KIND_CLEAR, 8'h00, 7'h00, 5'h00));
        issue_word(read_word(4, 0));
    endtask

    // The response side is held off while the command side keeps offering words.
    task automatic test_backpressure();
        hold_ticket++;
        for (int i = 0; i < 16; i++)
        begin
            if (i % 2 == 0)
            begin
                issue_word(put_word(CH_NEWLINE));
            end
            else
            begin
                issue_word(read_word($urandom_range(0, 3), pen_row));
            end
        end
    endtask

    task automatic test_random_text(input int unsigned count);
        int unsigned sent;
        int unsigned span;
        int unsigned pick;
        sent = 0;
        while (sent < count)
        begin
            span = ($urandom_range(0, 19) == 0) ? $urandom_range(70, 90) : $urandom_range(0, 4);
            for (int i = 0; i < span && sent < count; i++)
            begin
                issue_word(text_item());
                sent++;
            end
            pick = $urandom_range(0, 99);
            if (pick < 75)
            begin
                issue_word(put_word(CH_NEWLINE));
                sent++;
            end
            else if (pick < 83)
            begin
                issue_word(put_word(CH_RETURN));
                sent++;
            end
            else if (pick < 85)
            begin
                issue_word(make_word(KIND_CLEAR, 8'($urandom_range(0, 255)),
                                     7'($urandom_range(0, 127)), 5'($urandom_range(0, 31))));
                sent++;
            end
            else if (pick < 88)
            begin
                issue_word(make_word(KIND_NONE, 8'($urandom_range(0, 255)),
                                     7'($urandom_range(0, 127)), 5'($urandom_range(0, 31))));
                sent++;
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (hold_seen != hold_ticket)
        begin
            hold_seen <= hold_ticket;
            hold_left <= HOLD_CYCLES;
            rsp_stall <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            rsp_stall <= 1'b1;
        end
        else
        begin
            rsp_stall <= !steady && ($urandom_range(0, 99) < 20);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            rsp_seen++;
            if (expected_rsp.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                begin
                    $display("Response word %0d arrived with none expected", rsp_seen);
                end
            end
            else
            begin
                want = expected_rsp.pop_front();
                if (rsp_word !== want)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                    begin
                        $display({"Response word %0d: expected col %0d row %0d char %02h",
                                  " color %02h scrolled %0b"},
                                 rsp_seen, want.cursor_col, want.cursor_row, want.cell_char,
                                 want.cell_color, want.scrolled);
                        $display("    got col %0d row %0d char %02h color %02h scrolled %0b",
                                 rsp_word.cursor_col, rsp_word.cursor_row, rsp_word.cell_char,
                                 rsp_word.cell_color, rsp_word.scrolled);
                    end
                end
            end
        end
    end

    initial
    begin
        for (int i = 0; i < CELLS; i++)
        begin
            screen[i] = {RESET_COLOR, CH_BLANK};
        end
        pen_col = 0;
        pen_row = 0;
        ink = RESET_COLOR;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        test_power_up_screen();
        drain_responses();
        set_color(8'h00);
        test_control_codes();
        test_backpressure();
        drain_responses();
        set_color(8'hFF);
        test_random_text(75);
        drain_responses();
        set_color(8'($urandom_range(0, 255)));
        steady = 1'b1;
        test_random_text(75);
        drain_responses();
        steady = 1'b0;
        set_color(RESET_COLOR);
        test_random_text(75);
        drain_responses();
        set_color(8'($urandom_range(0, 255)));
        test_random_text(75);
        drain_responses();
        repeat (20) @(posedge clk);

        if (expected_rsp.size() != 0)
        begin
            $display("%0d response words never arrived", expected_rsp.size());
            mismatch_count += expected_rsp.size();
        end
        $display("Checked %0d command words (%0d cell reads, %0d clears) under five text colors,",
                 cmd_count, read_count, clear_count);
        $display("with %0d scrolls and one long response hold-off; %0d mismatches.",
                 scroll_count, mismatch_count);
        if (mismatch_count == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
